### rtl/scm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sample channel mixer package
// Shared widths, codes, constants and types of the multichannel sample mixer.
// ----------------------------------------------------------------------------
package scm_pkg;

  localparam int unsigned CHANNELS_DEF     = 24;
  localparam int unsigned SAMPLE_DEPTH_DEF = 1024;

  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned CHANNEL_W = 5;
  localparam int unsigned INDEX_W   = 10;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned LENGTH_W  = 11;
  localparam int unsigned LSTART_W  = 10;
  localparam int unsigned LEND_W    = 11;
  localparam int unsigned VOLUME_W  = 8;
  localparam int unsigned MASTER_W  = 8;
  localparam int unsigned GAIN_W    = VOLUME_W + MASTER_W;
  localparam int unsigned PROD_W    = SAMPLE_W + GAIN_W + 1;

  localparam logic [VOLUME_W-1:0] VOLUME_RESET = 8'd127;
  localparam logic [MASTER_W-1:0] MASTER_RESET = 8'd100;

  localparam int unsigned GAIN_DIVISOR = 127 * 100;
  localparam int unsigned RECIP_SHIFT  = 29;
  localparam int unsigned RECIP_MULT   = (1 << RECIP_SHIFT) / GAIN_DIVISOR;
  localparam int unsigned RECIP_W      = 16;
  localparam int unsigned SAT_LIMIT    = 32768 * GAIN_DIVISOR;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7fff;

  typedef enum logic [ACTION_W-1:0] {
    ACT_WRITE  = 3'd0,
    ACT_LENGTH = 3'd1,
    ACT_ACTIVE = 3'd2,
    ACT_MIX    = 3'd3,
    ACT_LOOP   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

### rtl/scm_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Mixer request channel
// Valid/ready channel that carries one mixer request.
// ----------------------------------------------------------------------------
interface scm_req_if import scm_pkg::*; ();

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic [CHANNEL_W-1:0]       channel;
  logic [INDEX_W-1:0]         sample_index;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic [LENGTH_W-1:0]        sample_length;
  logic [LSTART_W-1:0]        wrap_start;
  logic [LEND_W-1:0]          wrap_end;
  logic [VOLUME_W-1:0]        volume;
  logic                       active;

  modport source (
    output valid, action, channel, sample_index, sample_value, sample_length,
           wrap_start, wrap_end, volume, active,
    input  ready
  );

  modport sink (
    input  valid, action, channel, sample_index, sample_value, sample_length,
           wrap_start, wrap_end, volume, active,
    output ready
  );

endinterface
`default_nettype wire

### rtl/scm_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Mixer response channel
// Valid/ready channel that carries one mixed output sample.
// ----------------------------------------------------------------------------
interface scm_rsp_if import scm_pkg::*; ();

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mixed_sample;

  modport source (
    output valid, mixed_sample,
    input  ready
  );

  modport sink (
    input  valid, mixed_sample,
    output ready
  );

endinterface
`default_nettype wire

### rtl/sample_channel_mixer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sample channel mixer
// Mixes CHANNELS looping PCM channels from one sample memory into 16-bit
// output samples.
// ----------------------------------------------------------------------------
// Requests that write a sample, set a length, set a channel active or set loop
// points and volume take effect on acceptance. No request is taken while a mix
// runs: the channels are read one per cycle through the single read port of
// the sample memory and then pass a four-stage scale, divide and clamp
// pipeline into the accumulator. The result sits in an output register, so the
// next request is taken while it waits; a later mix result that finds the
// register still full holds the input until the waiting one is taken. The
// sample memory is not cleared after reset.
// ----------------------------------------------------------------------------
module sample_channel_mixer import scm_pkg::*; #(
  parameter int unsigned CHANNELS     = CHANNELS_DEF,
  parameter int unsigned SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire [MASTER_W-1:0]  cfg_wdata_i,
  scm_req_if.sink             req_i,
  scm_rsp_if.source           rsp_o
);

  localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CNT_W  = $clog2(CHANNELS + 1);
  localparam int unsigned LEN_W  = $clog2(SAMPLE_DEPTH + 1);
  localparam int unsigned POS_W  = (LEN_W > LSTART_W) ? LEN_W : LSTART_W;
  localparam int unsigned MEM_D  = CHANNELS * SAMPLE_DEPTH;
  localparam int unsigned ADDR_W = $clog2(MEM_D);
  localparam int unsigned MAG_W  = RECIP_SHIFT;
  localparam int unsigned RP_W   = MAG_W + RECIP_W;

  logic [MASTER_W-1:0] master_q;

  logic                active_q [CHANNELS];
  logic                loaded_q [CHANNELS];
  logic [POS_W-1:0]    pos_q    [CHANNELS];
  logic [LEN_W-1:0]    len_q    [CHANNELS];
  logic [LSTART_W-1:0] lstart_q [CHANNELS];
  logic [LEND_W-1:0]   lend_q   [CHANNELS];
  logic [VOLUME_W-1:0] vol_q    [CHANNELS];

  logic [SAMPLE_W-1:0] mem [MEM_D];
  logic [SAMPLE_W-1:0] mem_rdata_q;

  state_e state_q, state_d;
  logic   in_ready, issue, start, load_out;

  logic [CNT_W-1:0]    cnt_q;
  logic [SAMPLE_W-1:0] acc_q;
  logic                rsp_valid_q;
  logic [SAMPLE_W-1:0] rsp_data_q;

  // Request decode.
  logic            req_fire, ch_ok, idx_ok;
  logic [CH_W-1:0] req_ch;
  logic [LEN_W-1:0] len_sat;
  logic            mem_we;
  logic [ADDR_W-1:0] mem_waddr;

  assign req_fire  = req_i.valid && req_i.ready;
  assign req_ch    = CH_W'(req_i.channel);
  assign ch_ok     = 32'(req_i.channel) < CHANNELS;
  assign idx_ok    = 32'(req_i.sample_index) < SAMPLE_DEPTH;
  assign len_sat   = (32'(req_i.sample_length) > SAMPLE_DEPTH) ?
                     LEN_W'(SAMPLE_DEPTH) : LEN_W'(req_i.sample_length);
  assign mem_we    = req_fire && ch_ok && idx_ok && (req_i.action == ACT_WRITE);
  assign mem_waddr = ADDR_W'(req_ch) * ADDR_W'(SAMPLE_DEPTH) +
                     ADDR_W'(req_i.sample_index);

  // Issue stage: the channel selected by the counter.
  logic [CH_W-1:0]  cur_ch;
  logic             live, at_end, loop_ok, contrib, pos_we;
  logic [POS_W-1:0] len_ext, lstart_ext, pos_eff, pos_next;
  logic [ADDR_W-1:0] mem_raddr;

  always_comb begin
    cur_ch     = cnt_q[CH_W-1:0];
    len_ext    = POS_W'(len_q[cur_ch]);
    lstart_ext = POS_W'(lstart_q[cur_ch]);
    live       = active_q[cur_ch] && loaded_q[cur_ch];
    at_end     = pos_q[cur_ch] >= len_ext;
    loop_ok    = LEND_W'(lstart_q[cur_ch]) < lend_q[cur_ch];
    pos_eff    = at_end ? lstart_ext : pos_q[cur_ch];
    contrib    = live && (pos_eff < len_ext) && (!at_end || loop_ok);
    pos_we     = issue && live && (!at_end || loop_ok);
    pos_next   = contrib ? pos_eff + POS_W'(1) : pos_eff;
    mem_raddr  = contrib ? ADDR_W'(cur_ch) * ADDR_W'(SAMPLE_DEPTH) + ADDR_W'(pos_eff)
                         : '0;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= req_i.sample_value;
    end
    mem_rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_q <= MASTER_RESET;
    end else if (cfg_we_i) begin
      master_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        active_q[i] <= 1'b0;
        loaded_q[i] <= 1'b0;
        pos_q[i]    <= '0;
        len_q[i]    <= '0;
        lstart_q[i] <= '0;
        lend_q[i]   <= '0;
        vol_q[i]    <= VOLUME_RESET;
      end
    end else begin
      if (req_fire && ch_ok) begin
        if (req_i.action == ACT_LENGTH) begin
          len_q[req_ch]    <= len_sat;
          pos_q[req_ch]    <= '0;
          loaded_q[req_ch] <= 1'b1;
        end
        if (req_i.action == ACT_ACTIVE) begin
          active_q[req_ch] <= req_i.active;
        end
        if (req_i.action == ACT_LOOP) begin
          lstart_q[req_ch] <= req_i.wrap_start;
          lend_q[req_ch]   <= req_i.wrap_end;
          vol_q[req_ch]    <= req_i.volume;
        end
      end
      if (pos_we) begin
        pos_q[cur_ch] <= pos_next;
      end
    end
  end

  // Scale, divide and clamp pipeline.
  logic                     p1_v_q, p2_v_q, p3_v_q, p4_v_q;
  logic [GAIN_W-1:0]        p1_gain_q;
  logic signed [PROD_W-1:0] p2_prod_q;
  logic [MAG_W-1:0]         p3_mag_q;
  logic [RECIP_W-1:0]       p3_q0_q;
  logic                     p3_neg_q, p3_sat_q;
  logic [SAMPLE_W-1:0]      p4_val_q;

  logic signed [PROD_W-1:0] prod_d;
  logic [31:0]              mag;
  logic [RP_W-1:0]          recip_prod;
  logic [MAG_W-1:0]         back, rem;
  logic [RECIP_W-1:0]       quot;
  logic [SAMPLE_W-1:0]      val_d;

  always_comb begin
    prod_d     = $signed(mem_rdata_q) * $signed({1'b0, p1_gain_q});
    mag        = p2_prod_q[PROD_W-1] ? 32'(-p2_prod_q) : 32'(p2_prod_q);
    recip_prod = RP_W'(mag[MAG_W-1:0]) * RP_W'(RECIP_MULT);
    back       = MAG_W'(p3_q0_q) * MAG_W'(GAIN_DIVISOR);
    rem        = p3_mag_q - back;
    quot       = p3_q0_q + RECIP_W'(rem >= MAG_W'(GAIN_DIVISOR));
    if (p3_sat_q) begin
      val_d = p3_neg_q ? SAMPLE_MIN : SAMPLE_MAX;
    end else begin
      val_d = p3_neg_q ? SAMPLE_W'(-quot) : SAMPLE_W'(quot);
    end
  end

  always_ff @(posedge clk_i) begin
    p1_gain_q <= GAIN_W'(vol_q[cur_ch]) * GAIN_W'(master_q);
    p2_prod_q <= prod_d;
    p3_mag_q  <= mag[MAG_W-1:0];
    p3_q0_q   <= recip_prod[RECIP_SHIFT +: RECIP_W];
    p3_neg_q  <= p2_prod_q[PROD_W-1];
    p3_sat_q  <= mag >= 32'(SAT_LIMIT);
    p4_val_q  <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
    end else begin
      p1_v_q <= issue && contrib;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
      p4_v_q <= p3_v_q;
    end
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    in_ready = 1'b0;
    issue    = 1'b0;
    start    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (req_i.valid && (req_i.action == ACT_MIX)) begin
          start   = 1'b1;
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_q != CNT_W'(CHANNELS)) begin
          issue = 1'b1;
        end else if (!(p1_v_q || p2_v_q || p3_v_q || p4_v_q)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign req_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      acc_q       <= '0;
      rsp_valid_q <= 1'b0;
      rsp_data_q  <= '0;
    end else begin
      if (start) begin
        cnt_q <= '0;
        acc_q <= '0;
      end else begin
        if (issue) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
        if (p4_v_q) begin
          acc_q <= acc_q + p4_val_q;
        end
      end
      if (load_out) begin
        rsp_valid_q <= 1'b1;
        rsp_data_q  <= acc_q;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.mixed_sample = rsp_data_q;

endmodule
`default_nettype wire
